// File: hdl/avs_pkg.sv
package avs_pkg;

    // Activation select codes, as written to the configuration register
    typedef enum logic [1:0] {
        KIND_LINEAR  = 2'd0,
        KIND_SIGMOID = 2'd1,
        KIND_RELU    = 2'd2,
        KIND_TANH    = 2'd3
    } kind_t;

    // Q30 constants for building the tanh knot table
    localparam logic [63:0] Q30_ONE           = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF          = 64'd1 << 29;
    localparam logic [63:0] Q30_MASK          = (64'd1 << 30) - 64'd1;
    localparam logic [63:0] EXP_MINUS_ONE_Q30 = 64'd395007542;

endpackage

// File: hdl/activation_value_and_slope.sv
// Activation value and slope: linear, sigmoid, ReLU or tanh on one Q4.12 word.
// Throughput: one word per cycle unless stalled; the six stages (scale, knot ROM read,
// interpolation, value select, slope multiply, round and saturate) each take one word.
// Reset (aresetn low at a clock edge) empties every stage and sets the kind to linear.
// The knot ROM holds TABLE_SEGMENTS + 1 entries and is built at elaboration.
module activation_value_and_slope #(
    parameter int FRAC_BITS      = 12,
    parameter int TABLE_SEGMENTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_activated,
    output logic        [12:0] m_slope,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_data
);

    localparam int NST   = 6;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int TW    = FRAC_BITS + 1;
    localparam int IW    = $clog2(TABLE_SEGMENTS + 1);
    localparam int MULW  = 16 + IW;
    localparam int SHIFT = FRAC_BITS + 4;
    localparam int NW    = (MULW + 1 > SHIFT + 1) ? MULW + 1 : SHIFT + 1;
    localparam int KW    = NW - SHIFT;
    localparam int PW    = TW + SHIFT;
    localparam int MW    = 2 * TW;
    localparam int YW    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;

    localparam logic [TW-1:0]        ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [YW-1:0] Y_MAX  = YW'(32767);
    localparam logic signed [YW-1:0] Y_MIN  = YW'(-32768);
    localparam logic signed [YW-1:0] Y_ONE  = YW'(ONE);
    localparam logic [PW-1:0]        P_HALF = PW'(1) << (SHIFT - 1);
    localparam logic [MW-1:0]        M_HALF = MW'(ONE / 2);

    // Unsigned 64-bit restoring division, used only while building the ROM
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8k / TABLE_SEGMENTS) at FRAC_BITS, from a Q30 exponential
    function automatic logic [63:0] knot_value(input logic [63:0] k);
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] en;
        logic [63:0] term;
        logic [63:0] ef;
        logic [63:0] enf;
        logic [63:0] e;
        logic [63:0] d;
        u    = udiv(k << 34, 64'(TABLE_SEGMENTS));
        n    = u >> 30;
        f    = u & avs_pkg::Q30_MASK;
        en   = avs_pkg::Q30_ONE;
        for (int i = 0; i < 64; i++) begin
            if (64'(i) < n) begin
                en = (en * avs_pkg::EXP_MINUS_ONE_Q30 + avs_pkg::Q30_HALF) >> 30;
            end
        end
        term = avs_pkg::Q30_ONE;
        ef   = avs_pkg::Q30_ONE;
        for (int i = 1; i < 48; i++) begin
            term = udiv((term * f) >> 30, 64'(i));
            ef   = ef + term;
        end
        enf = udiv((64'd1 << 60) + (ef >> 1), ef);
        e   = (en * enf + avs_pkg::Q30_HALF) >> 30;
        if (e > avs_pkg::Q30_ONE) begin
            e = avs_pkg::Q30_ONE;
        end
        d = avs_pkg::Q30_ONE + e;
        return udiv(((avs_pkg::Q30_ONE - e) << FRAC_BITS) + (d >> 1), d);
    endfunction

    function automatic logic [TABLE_SEGMENTS:0][TW-1:0] build_lo();
        logic [TABLE_SEGMENTS:0][TW-1:0] tab;
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            tab[k] = TW'(knot_value(64'(k)));
        end
        return tab;
    endfunction

    // Rise to the next knot; the last entry is flat so saturation needs no extra path
    function automatic logic [TABLE_SEGMENTS:0][TW-1:0] build_diff();
        logic [TABLE_SEGMENTS:0][TW-1:0] tab;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            tab[k] = '0;
            if (k < TABLE_SEGMENTS) begin
                lo = knot_value(64'(k));
                hi = knot_value(64'(k + 1));
                if (hi >= lo) begin
                    tab[k] = TW'(hi - lo);
                end
            end
        end
        return tab;
    endfunction

    localparam logic [TABLE_SEGMENTS:0][TW-1:0] KNOT_LO   = build_lo();
    localparam logic [TABLE_SEGMENTS:0][TW-1:0] KNOT_DIFF = build_diff();

    // Control state
    logic [NST-1:0]  vld_reg;
    logic [NST-1:0]  adv;
    avs_pkg::kind_t  kind_reg;

    // Stage 1: scaled magnitude
    logic [NW-1:0]          st1_num_reg;
    logic signed [15:0]     st1_x_reg;
    logic                   st1_neg_reg;
    logic                   st1_pos_reg;
    avs_pkg::kind_t         st1_kind_reg;
    // Stage 2: knot ROM read
    logic [TW-1:0]          st2_lo_reg;
    logic [TW-1:0]          st2_diff_reg;
    logic [SHIFT-1:0]       st2_r_reg;
    logic signed [15:0]     st2_x_reg;
    logic                   st2_neg_reg;
    logic                   st2_pos_reg;
    avs_pkg::kind_t         st2_kind_reg;
    // Stage 3: interpolated tanh
    logic [TW-1:0]          st3_t_reg;
    logic signed [15:0]     st3_x_reg;
    logic                   st3_neg_reg;
    logic                   st3_pos_reg;
    avs_pkg::kind_t         st3_kind_reg;
    // Stage 4: value and slope operands
    logic signed [YW-1:0]   st4_y_reg;
    logic [TW-1:0]          st4_ma_reg;
    logic [TW-1:0]          st4_mb_reg;
    logic                   st4_pos_reg;
    avs_pkg::kind_t         st4_kind_reg;
    // Stage 5: slope product
    logic [MW-1:0]          st5_prod_reg;
    logic signed [YW-1:0]   st5_y_reg;
    logic                   st5_pos_reg;
    avs_pkg::kind_t         st5_kind_reg;
    // Stage 6: output word
    logic signed [15:0]     m_activated_reg;
    logic [12:0]            m_slope_reg;

    // Combinational next values
    logic [15:0]            mag;
    logic [MULW-1:0]        num_mul;
    logic [NW-1:0]          st1_num_next;
    logic [KW-1:0]          kfull;
    logic [IW-1:0]          rom_idx;
    logic [PW-1:0]          interp;
    logic [TW-1:0]          st3_t_next;
    logic [TW:0]            p_wide;
    logic [TW-1:0]          ysig;
    logic [YW-1:0]          tmag;
    logic signed [YW-1:0]   st4_y_next;
    logic [TW-1:0]          st4_ma_next;
    logic [TW-1:0]          st4_mb_next;
    logic [MW-1:0]          rq_wide;
    logic [TW-1:0]          rq;
    logic [TW-1:0]          slope_full;
    logic [12:0]            m_slope_next;
    logic signed [15:0]     m_activated_next;

    // Advance a stage when it is empty or the one after it advances
    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready     = adv[0];
    assign m_valid     = vld_reg[NST-1];
    assign cfg_ready   = 1'b1;
    assign m_activated = m_activated_reg;
    assign m_slope     = m_slope_reg;

    // Stage 1: take the magnitude and scale it onto the knot grid
    always_comb begin
        mag     = s_sample_in[15] ? 16'(~s_sample_in + 16'sd1) : 16'(s_sample_in);
        num_mul = MULW'(mag) * MULW'(TABLE_SEGMENTS);
        if (kind_reg == avs_pkg::KIND_TANH) begin
            st1_num_next = NW'(num_mul) << 1;
        end else begin
            st1_num_next = NW'(num_mul);
        end
    end

    // Stage 2: segment index, clamped to the last knot beyond the table
    always_comb begin
        kfull = st1_num_reg[NW-1:SHIFT];
        if (32'(kfull) >= TABLE_SEGMENTS) begin
            rom_idx = IW'(TABLE_SEGMENTS);
        end else begin
            rom_idx = IW'(kfull);
        end
    end

    // Stage 3: interpolate within the segment, rounding half up
    always_comb begin
        interp     = PW'(st2_diff_reg) * PW'(st2_r_reg) + P_HALF;
        st3_t_next = st2_lo_reg + TW'(interp >> SHIFT);
    end

    // Stage 4: select the value and the slope factors
    always_comb begin
        p_wide      = {1'b0, ONE_T} + {1'b0, st3_t_reg} + (TW+1)'(1);
        ysig        = st3_neg_reg ? ONE_T - p_wide[TW:1] : p_wide[TW:1];
        tmag        = YW'(st3_t_reg);
        st4_y_next  = YW'(st3_x_reg);
        st4_ma_next = '0;
        st4_mb_next = '0;
        case (st3_kind_reg)
            avs_pkg::KIND_LINEAR: begin
                st4_y_next = YW'(st3_x_reg);
            end
            avs_pkg::KIND_SIGMOID: begin
                st4_y_next  = YW'(ysig);
                st4_ma_next = ysig;
                st4_mb_next = ONE_T - ysig;
            end
            avs_pkg::KIND_RELU: begin
                st4_y_next = st3_pos_reg ? YW'(st3_x_reg) : '0;
            end
            avs_pkg::KIND_TANH: begin
                st4_y_next  = st3_neg_reg ? -tmag : tmag;
                st4_ma_next = st3_t_reg;
                st4_mb_next = st3_t_reg;
            end
            default: begin
                st4_y_next = YW'(st3_x_reg);
            end
        endcase
    end

    // Stage 6: round the product, form the slope, saturate both fields
    always_comb begin
        rq_wide = st5_prod_reg + M_HALF;
        rq      = TW'(rq_wide >> FRAC_BITS);
        case (st5_kind_reg)
            avs_pkg::KIND_LINEAR:  slope_full = ONE_T;
            avs_pkg::KIND_SIGMOID: slope_full = rq;
            avs_pkg::KIND_RELU:    slope_full = st5_pos_reg ? ONE_T : '0;
            avs_pkg::KIND_TANH:    slope_full = ONE_T - rq;
            default:               slope_full = ONE_T;
        endcase
        m_slope_next = (32'(slope_full) > 8191) ? 13'd8191 : 13'(slope_full);
        if (st5_y_reg > Y_MAX) begin
            m_activated_next = 16'sh7FFF;
        end else if (st5_y_reg < Y_MIN) begin
            m_activated_next = -16'sh8000;
        end else begin
            m_activated_next = 16'(st5_y_reg);
        end
    end

    // Hold the kind register and move valid bits down the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            kind_reg <= avs_pkg::KIND_LINEAR;
        end else begin
            if (cfg_valid) begin
                kind_reg <= avs_pkg::kind_t'(cfg_data);
            end
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Advance the payload of each stage together with its valid bit
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_num_reg  <= st1_num_next;
            st1_x_reg    <= s_sample_in;
            st1_neg_reg  <= s_sample_in[15];
            st1_pos_reg  <= !s_sample_in[15] && (|s_sample_in);
            st1_kind_reg <= kind_reg;
        end
        if (adv[1]) begin
            st2_lo_reg   <= KNOT_LO[rom_idx];
            st2_diff_reg <= KNOT_DIFF[rom_idx];
            st2_r_reg    <= st1_num_reg[SHIFT-1:0];
            st2_x_reg    <= st1_x_reg;
            st2_neg_reg  <= st1_neg_reg;
            st2_pos_reg  <= st1_pos_reg;
            st2_kind_reg <= st1_kind_reg;
        end
        if (adv[2]) begin
            st3_t_reg    <= st3_t_next;
            st3_x_reg    <= st2_x_reg;
            st3_neg_reg  <= st2_neg_reg;
            st3_pos_reg  <= st2_pos_reg;
            st3_kind_reg <= st2_kind_reg;
        end
        if (adv[3]) begin
            st4_y_reg    <= st4_y_next;
            st4_ma_reg   <= st4_ma_next;
            st4_mb_reg   <= st4_mb_next;
            st4_pos_reg  <= st3_pos_reg;
            st4_kind_reg <= st3_kind_reg;
        end
        if (adv[4]) begin
            st5_prod_reg <= MW'(st4_ma_reg) * MW'(st4_mb_reg);
            st5_y_reg    <= st4_y_reg;
            st5_pos_reg  <= st4_pos_reg;
            st5_kind_reg <= st4_kind_reg;
        end
        if (adv[5]) begin
            m_activated_reg <= m_activated_next;
            m_slope_reg     <= m_slope_next;
        end
    end

`ifndef SYNTHESIS
    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A word in stage 1 moves on when stage 2 advances
    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && adv[1] |=> vld_reg[1])
        else $error("word lost between stage 1 and stage 2");

    // Interpolated tanh never exceeds one
    a_tanh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> st3_t_reg <= ONE_T)
        else $error("interpolated tanh above one");

    // Sigmoid value stays within zero and one
    a_sigmoid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && st4_kind_reg == avs_pkg::KIND_SIGMOID
        |-> !st4_y_reg[YW-1] && st4_y_reg <= Y_ONE)
        else $error("sigmoid value out of range");
`endif

endmodule

// File: sim/avs_checker.sv
`timescale 1ns / 1ps

module avs_checker #(
    parameter int FRAC_BITS      = 12,
    parameter int TABLE_SEGMENTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_activated,
    input  logic        [12:0] m_slope,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic        [1:0]  cfg_data,
    output int                 mismatch_count,
    output int                 words_in_flight
);

    localparam longint ONE_FX = longint'(1) << FRAC_BITS;

    typedef struct {
        logic signed [15:0] sample;
        avs_pkg::kind_t     kind;
        logic signed [15:0] activated;
        logic        [12:0] slope;
    } act_result_t;

    act_result_t       predicted_results[$];
    longint unsigned   tanh_knots[0:TABLE_SEGMENTS];
    avs_pkg::kind_t    active_kind;

    // tanh(8k/TABLE_SEGMENTS) at FRAC_BITS, built from Q30 exponentials
    function automatic longint unsigned tanh_knot(longint unsigned k);
        longint unsigned u, n, f, en, term, ef, enf, e, d, i;
        u = (k << 34) / longint'(TABLE_SEGMENTS);
        n = u >> 30;
        f = u & avs_pkg::Q30_MASK;
        en = avs_pkg::Q30_ONE;
        for (i = 0; i < n && i < 64; i++)
            en = (en * avs_pkg::EXP_MINUS_ONE_Q30 + avs_pkg::Q30_HALF) >> 30;
        term = avs_pkg::Q30_ONE;
        ef = avs_pkg::Q30_ONE;
        for (i = 1; i < 48 && term != 0; i++) begin
            term = ((term * f) >> 30) / i;
            ef += term;
        end
        enf = ((64'd1 << 60) + ef / 2) / ef;
        e = (en * enf + avs_pkg::Q30_HALF) >> 30;
        if (e > avs_pkg::Q30_ONE)
            e = avs_pkg::Q30_ONE;
        d = avs_pkg::Q30_ONE + e;
        return (((avs_pkg::Q30_ONE - e) << FRAC_BITS) + d / 2) / d;
    endfunction

    // Interpolate tanh of mag * 2^-half_shift, holding the last knot past the table
    function automatic longint unsigned interp_tanh(longint unsigned mag, int half_shift);
        longint unsigned num, den, seg, rem, lo, hi, diff;
        num = mag * longint'(TABLE_SEGMENTS);
        den = 64'd8 << (FRAC_BITS + half_shift);
        seg = num / den;
        rem = num % den;
        if (seg >= longint'(TABLE_SEGMENTS))
            return tanh_knots[TABLE_SEGMENTS];
        lo = tanh_knots[seg];
        hi = tanh_knots[seg + 1];
        diff = (hi >= lo) ? hi - lo : 64'd0;
        return lo + (diff * rem + den / 2) / den;
    endfunction

    // Value and slope of one sample under the selected activation
    function automatic act_result_t activate_sample(avs_pkg::kind_t kind,
                                                    logic signed [15:0] sample);
        act_result_t res;
        longint x, mag, y, s, t, p;
        x = sample;
        mag = (x < 0) ? -x : x;
        case (kind)
            avs_pkg::KIND_SIGMOID: begin
                t = longint'(interp_tanh(mag, 1));
                p = (ONE_FX + t + 1) >>> 1;
                y = (x >= 0) ? p : ONE_FX - p;
                s = (y * (ONE_FX - y) + ONE_FX / 2) >>> FRAC_BITS;
            end
            avs_pkg::KIND_RELU: begin
                y = (x > 0) ? x : 0;
                s = (x > 0) ? ONE_FX : 0;
            end
            avs_pkg::KIND_TANH: begin
                t = longint'(interp_tanh(mag, 0));
                y = (x >= 0) ? t : -t;
                s = ONE_FX - ((t * t + ONE_FX / 2) >>> FRAC_BITS);
            end
            default: begin
                y = x;
                s = ONE_FX;
            end
        endcase
        // Saturate to the port widths
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        if (s < 0)
            s = 0;
        if (s > 8191)
            s = 8191;
        res.sample = sample;
        res.kind = kind;
        res.activated = y[15:0];
        res.slope = s[12:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("avs_checker: %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare one output word with the oldest prediction
    task automatic check_word(input logic signed [15:0] act, input logic [12:0] slope);
        act_result_t want;
        if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word activated=%0d slope=%0d", act, slope));
            return;
        end
        want = predicted_results.pop_front();
        if (act !== want.activated)
            report_mismatch($sformatf("%s x=%0d: activated %0d, want %0d",
                                      want.kind.name(), want.sample, act, want.activated));
        if (slope !== want.slope)
            report_mismatch($sformatf("%s x=%0d: slope %0d, want %0d",
                                      want.kind.name(), want.sample, slope, want.slope));
    endtask

    initial begin
        mismatch_count = 0;
        words_in_flight = 0;
        active_kind = avs_pkg::KIND_LINEAR;
        for (int k = 0; k <= TABLE_SEGMENTS; k++)
            tanh_knots[k] = tanh_knot(k);
    end

    // Track the register, predict on each accepted sample, check each result
    always @(posedge aclk) begin
        if (!aresetn) begin
            active_kind = avs_pkg::KIND_LINEAR;
            predicted_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                active_kind = avs_pkg::kind_t'(cfg_data);
            if (s_valid && s_ready)
                predicted_results.push_back(activate_sample(active_kind, s_sample_in));
            if (m_valid && m_ready)
                check_word(m_activated, m_slope);
        end
        words_in_flight = predicted_results.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_SAMPLES = 54;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_activated;
    logic        [12:0] m_slope;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [1:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int mismatch_count;
    int words_in_flight;

    activation_value_and_slope dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_activated (m_activated),
        .m_slope     (m_slope),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    avs_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_activated     (m_activated),
        .m_slope         (m_slope),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one sample, with random gaps ahead of it; return at the falling edge
    task automatic push_sample(input logic signed [15:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold the input until every predicted word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge aclk);
    endtask

    task automatic write_kind(input avs_pkg::kind_t kind);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= kind;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mix full-range samples, the bend of the curves, and knot edges
    function automatic logic signed [15:0] random_sample();
        int pick, v;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            v = int'($urandom_range(0, 65535));
        end else if (pick < 80) begin
            v = int'($urandom_range(0, 16384)) - 8192;
        end else begin
            v = int'($urandom_range(0, 64)) * 512 + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v[15:0];
    endfunction

    initial begin
        avs_pkg::kind_t     kinds[4] = '{avs_pkg::KIND_LINEAR, avs_pkg::KIND_SIGMOID,
                                         avs_pkg::KIND_RELU, avs_pkg::KIND_TANH};
        logic signed [15:0] corners[6] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                           16'sh0001, 16'shffff, 16'sh01ff};
        int                 mode;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes, zero crossing and a knot edge under every kind
        foreach (kinds[i]) begin
            write_kind(kinds[i]);
            foreach (corners[j])
                push_sample(corners[j]);
        end

        // Random: three idle patterns, each through all four kinds
        for (int phase = 0; phase < 12; phase++) begin
            mode = phase / 4;
            write_kind(kinds[(phase + mode) % 4]);
            case (mode)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (PHASE_SAMPLES)
                push_sample(random_sample());
        end

        drain_results();
        repeat (20) @(negedge aclk);

        if (mismatch_count == 0 && words_in_flight == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/avs_pkg.sv
hdl/activation_value_and_slope.sv
sim/avs_checker.sv
sim/tb.sv
